// ----- src/crcfr_pkg.sv -----
package crcfr_pkg;

    localparam logic [7:0]  START_PLAIN  = 8'hA5;
    localparam logic [7:0]  START_ANSWER = 8'h5A;
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'h1021;

    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd500;
    localparam logic [63:0] TYPE_MASK_RESET   = 64'd1023;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MAX_PAYLOAD = 2'd0,
        REG_TYPE_MASK   = 2'd1
    } t_reg_index;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_TYPE    = 3'd1,
        PH_LEN_HI  = 3'd2,
        PH_LEN_LO  = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CRC_HI  = 3'd5,
        PH_CRC_LO  = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_START = 3'd1,
        ST_OVERFLOW  = 3'd2,
        ST_BAD_CRC   = 3'd3,
        ST_BAD_TYPE  = 3'd4
    } t_status;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_STATUS  = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  payload_byte;
        t_status     status;
        logic [7:0]  frame_type;
        logic        answer_start;
        logic [15:0] frame_length;
    } t_result;

endpackage

// ----- src/crcfr_in_if.sv -----
interface crcfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       restart;

    modport source (output valid, output rx_byte, output restart, input ready);
    modport sink   (input valid, input rx_byte, input restart, output ready);
endinterface

// ----- src/crcfr_out_if.sv -----
interface crcfr_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  payload_byte;
    logic [2:0]  status;
    logic [7:0]  frame_type;
    logic        answer_start;
    logic [15:0] frame_length;

    modport source (
        output valid, output kind, output payload_byte, output status,
        output frame_type, output answer_start, output frame_length,
        input ready
    );
    modport sink (
        input valid, input kind, input payload_byte, input status,
        input frame_type, input answer_start, input frame_length,
        output ready
    );
endinterface

// ----- src/crcfr_crc16.sv -----
module crcfr_crc16 (
    input  logic [15:0] i_crc,
    input  logic [7:0]  i_byte,
    output logic [15:0] o_crc
);

    always_comb begin
        logic [15:0] c;
        c = i_crc ^ {i_byte, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ crcfr_pkg::CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        o_crc = c;
    end

endmodule

// ----- src/crc_framed_packet_receiver.sv -----
// Channel  | Direction | Word
// ---------+-----------+-------------------------------------------------------
// i_rx     | in        | rx_byte[7:0], restart
// o_res    | out       | kind, payload_byte[7:0], status[2:0], frame_type[7:0],
//          |           | answer_start, frame_length[15:0]
// cfg      | in        | i_cfg_we, i_cfg_index[1:0], i_cfg_data[63:0]
//
// One word is taken per cycle while i_rx.ready is high; a word that yields a
// result writes it to the output register on the same edge that accepts it.
// i_rx.ready drops only while a result sits in the output register and
// o_res.ready is low. Reset is synchronous on i_rst_n low: the receiver hunts
// for a start byte and both registers return to 500 and 0x3FF.
module crc_framed_packet_receiver (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    crcfr_in_if.sink                            i_rx,
    crcfr_out_if.source                         o_res,
    input  logic                                i_cfg_we,
    input  logic [crcfr_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [crcfr_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    crcfr_pkg::t_phase  r_phase,  n_phase;
    logic [15:0]        r_crc,    n_crc;
    logic [7:0]         r_type,   n_type;
    logic [15:0]        r_length, n_length;
    logic [15:0]        r_count,  n_count;
    logic               r_start,  n_start;
    logic [7:0]         r_crc_hi, n_crc_hi;
    logic               r_junk,   n_junk;

    logic [15:0]        r_max_payload;
    logic [63:0]        r_type_mask;

    logic               r_out_valid;
    crcfr_pkg::t_result r_out, n_out;
    logic               n_emit;

    logic               accept;
    logic [15:0]        crc_upd;
    logic [15:0]        len_full;
    logic [15:0]        count_inc;
    logic               type_ok;

    crcfr_crc16 u_crc (
        .i_crc  (r_phase == crcfr_pkg::PH_HUNT ? crcfr_pkg::CRC_INIT : r_crc),
        .i_byte (i_rx.rx_byte),
        .o_crc  (crc_upd)
    );

    assign i_rx.ready = !r_out_valid || o_res.ready;
    assign accept     = i_rx.valid && i_rx.ready;
    assign len_full   = {r_length[15:8], i_rx.rx_byte};
    assign count_inc  = r_count + 16'd1;
    assign type_ok    = (r_type[7:6] == 2'b00) && r_type_mask[r_type[5:0]];

    always_comb begin
        n_phase  = r_phase;
        n_crc    = r_crc;
        n_type   = r_type;
        n_length = r_length;
        n_count  = r_count;
        n_start  = r_start;
        n_crc_hi = r_crc_hi;
        n_junk   = r_junk;
        n_emit   = 1'b0;

        n_out.kind         = crcfr_pkg::KIND_STATUS;
        n_out.payload_byte = 8'h00;
        n_out.status       = crcfr_pkg::ST_OK;
        n_out.frame_type   = r_type;
        n_out.answer_start = r_start;
        n_out.frame_length = r_length;

        if (i_rx.restart) begin
            n_phase = crcfr_pkg::PH_HUNT;
            n_crc   = crcfr_pkg::CRC_INIT;
            n_count = 16'd0;
            n_junk  = 1'b0;
        end else begin
            case (r_phase)
                crcfr_pkg::PH_HUNT: begin
                    if (i_rx.rx_byte == crcfr_pkg::START_PLAIN ||
                        i_rx.rx_byte == crcfr_pkg::START_ANSWER) begin
                        n_start = (i_rx.rx_byte == crcfr_pkg::START_ANSWER);
                        n_crc   = crc_upd;
                        n_junk  = 1'b0;
                        n_phase = crcfr_pkg::PH_TYPE;
                    end else if (!r_junk) begin
                        n_junk             = 1'b1;
                        n_emit             = 1'b1;
                        n_out.status       = crcfr_pkg::ST_BAD_START;
                        n_out.frame_type   = 8'h00;
                        n_out.answer_start = 1'b0;
                        n_out.frame_length = 16'h0000;
                    end
                end
                crcfr_pkg::PH_TYPE: begin
                    n_type  = i_rx.rx_byte;
                    n_crc   = crc_upd;
                    n_phase = crcfr_pkg::PH_LEN_HI;
                end
                crcfr_pkg::PH_LEN_HI: begin
                    n_length = {i_rx.rx_byte, 8'h00};
                    n_crc    = crc_upd;
                    n_phase  = crcfr_pkg::PH_LEN_LO;
                end
                crcfr_pkg::PH_LEN_LO: begin
                    n_length = len_full;
                    n_crc    = crc_upd;
                    n_count  = 16'd0;
                    if (len_full > r_max_payload) begin
                        n_emit             = 1'b1;
                        n_out.status       = crcfr_pkg::ST_OVERFLOW;
                        n_out.frame_length = len_full;
                        n_phase            = crcfr_pkg::PH_HUNT;
                        n_crc              = crcfr_pkg::CRC_INIT;
                        n_junk             = 1'b0;
                    end else if (len_full == 16'd0) begin
                        n_phase = crcfr_pkg::PH_CRC_HI;
                    end else begin
                        n_phase = crcfr_pkg::PH_PAYLOAD;
                    end
                end
                crcfr_pkg::PH_PAYLOAD: begin
                    n_crc   = crc_upd;
                    n_count = count_inc;
                    if (count_inc >= r_length) begin
                        n_phase = crcfr_pkg::PH_CRC_HI;
                    end
                    n_emit             = 1'b1;
                    n_out.kind         = crcfr_pkg::KIND_PAYLOAD;
                    n_out.payload_byte = i_rx.rx_byte;
                end
                crcfr_pkg::PH_CRC_HI: begin
                    n_crc_hi = i_rx.rx_byte;
                    n_phase  = crcfr_pkg::PH_CRC_LO;
                end
                crcfr_pkg::PH_CRC_LO: begin
                    n_emit = 1'b1;
                    if (r_crc_hi != r_crc[15:8] || i_rx.rx_byte != r_crc[7:0]) begin
                        n_out.status = crcfr_pkg::ST_BAD_CRC;
                    end else if (!type_ok) begin
                        n_out.status = crcfr_pkg::ST_BAD_TYPE;
                    end
                    n_phase = crcfr_pkg::PH_HUNT;
                    n_crc   = crcfr_pkg::CRC_INIT;
                    n_count = 16'd0;
                    n_junk  = 1'b0;
                end
                default: begin
                    n_phase = crcfr_pkg::PH_HUNT;
                    n_crc   = crcfr_pkg::CRC_INIT;
                    n_count = 16'd0;
                    n_junk  = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= crcfr_pkg::PH_HUNT;
            r_crc    <= crcfr_pkg::CRC_INIT;
            r_type   <= 8'h00;
            r_length <= 16'h0000;
            r_count  <= 16'h0000;
            r_start  <= 1'b0;
            r_crc_hi <= 8'h00;
            r_junk   <= 1'b0;
        end else if (accept) begin
            r_phase  <= n_phase;
            r_crc    <= n_crc;
            r_type   <= n_type;
            r_length <= n_length;
            r_count  <= n_count;
            r_start  <= n_start;
            r_crc_hi <= n_crc_hi;
            r_junk   <= n_junk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= crcfr_pkg::MAX_PAYLOAD_RESET;
            r_type_mask   <= crcfr_pkg::TYPE_MASK_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                crcfr_pkg::REG_MAX_PAYLOAD: r_max_payload <= i_cfg_data[15:0];
                crcfr_pkg::REG_TYPE_MASK:   r_type_mask   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && n_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && n_emit) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.kind         = r_out.kind;
    assign o_res.payload_byte = r_out.payload_byte;
    assign o_res.status       = r_out.status;
    assign o_res.frame_type   = r_out.frame_type;
    assign o_res.answer_start = r_out.answer_start;
    assign o_res.frame_length = r_out.frame_length;

    a_junk_only_hunting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != crcfr_pkg::PH_HUNT) |-> !r_junk)
        else $error("junk flag set outside hunting");

    a_count_below_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == crcfr_pkg::PH_PAYLOAD) |-> (r_count < r_length))
        else $error("payload count reached length in payload phase");

    a_payload_status_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == crcfr_pkg::KIND_PAYLOAD)
            |-> (r_out.status == crcfr_pkg::ST_OK))
        else $error("payload word carries a status");

    a_overflow_hunts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_rx.restart && r_phase == crcfr_pkg::PH_LEN_LO &&
         len_full > r_max_payload) |=> (r_phase == crcfr_pkg::PH_HUNT))
        else $error("overflow did not return to hunting");

    a_result_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(accept))
        else $error("result appeared without an accepted word");

endmodule

// ----- bench/crc_framed_packet_receiver_tb.sv -----
module crc_framed_packet_receiver_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [crcfr_pkg::CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [crcfr_pkg::CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;
    localparam int RANDOM_PHASES = 6;
    localparam int WORDS_PER_PHASE = 315;
    localparam int REPORT_LINES = 40;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       restart;
    } t_rx_word;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n;
    logic                              cfg_we;
    logic [crcfr_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [crcfr_pkg::CFG_DATA_W-1:0]  cfg_data;

    crcfr_in_if  rx_if ();
    crcfr_out_if res_if ();

    crc_framed_packet_receiver uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx        (rx_if),
        .o_res       (res_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    t_rx_word           pending_q[$];
    crcfr_pkg::t_result expected_q[$];
    int                 pushed_total = 0;
    int                 mismatch_count = 0;
    int unsigned        send_idle_pct = 0;
    int unsigned        recv_idle_pct = 0;
    bit                 send_hold = 1'b0;
    bit                 recv_hold = 1'b0;

    logic [15:0] max_len_cfg = crcfr_pkg::MAX_PAYLOAD_RESET;
    logic [63:0] type_mask_cfg = crcfr_pkg::TYPE_MASK_RESET;

    crcfr_pkg::t_phase fr_phase = crcfr_pkg::PH_HUNT;
    logic [15:0] fr_crc = crcfr_pkg::CRC_INIT;
    logic [7:0]  fr_type = 8'h00;
    logic [15:0] fr_len = 16'h0000;
    logic [15:0] fr_count = 16'h0000;
    logic        fr_answer = 1'b0;
    logic [7:0]  fr_crc_hi = 8'h00;
    logic        fr_junk_seen = 1'b0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic [15:0] crc16_next(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
            c = c[15] ? ({c[14:0], 1'b0} ^ crcfr_pkg::CRC_POLY) : {c[14:0], 1'b0};
        return c;
    endfunction

    function automatic void post_result(crcfr_pkg::t_kind k, logic [7:0] data,
                                        crcfr_pkg::t_status st, bit with_frame);
        crcfr_pkg::t_result r;
        r.kind         = k;
        r.payload_byte = data;
        r.status       = st;
        r.frame_type   = with_frame ? fr_type : 8'h00;
        r.answer_start = with_frame ? fr_answer : 1'b0;
        r.frame_length = with_frame ? fr_len : 16'h0000;
        expected_q.push_back(r);
    endfunction

    function automatic void return_to_hunt();
        fr_phase     = crcfr_pkg::PH_HUNT;
        fr_crc       = crcfr_pkg::CRC_INIT;
        fr_count     = 16'h0000;
        fr_junk_seen = 1'b0;
    endfunction

    task automatic deframe_step(input logic [7:0] b, input logic abort);
        crcfr_pkg::t_status st;
        if (abort) begin
            return_to_hunt();
        end else begin
            case (fr_phase)
                crcfr_pkg::PH_HUNT: begin
                    if (b == crcfr_pkg::START_PLAIN || b == crcfr_pkg::START_ANSWER) begin
                        fr_answer    = (b == crcfr_pkg::START_ANSWER);
                        fr_crc       = crc16_next(crcfr_pkg::CRC_INIT, b);
                        fr_junk_seen = 1'b0;
                        fr_phase     = crcfr_pkg::PH_TYPE;
                    end else if (!fr_junk_seen) begin
                        fr_junk_seen = 1'b1;
                        post_result(crcfr_pkg::KIND_STATUS, 8'h00,
                                    crcfr_pkg::ST_BAD_START, 1'b0);
                    end
                end
                crcfr_pkg::PH_TYPE: begin
                    fr_type  = b;
                    fr_crc   = crc16_next(fr_crc, b);
                    fr_phase = crcfr_pkg::PH_LEN_HI;
                end
                crcfr_pkg::PH_LEN_HI: begin
                    fr_len   = {b, 8'h00};
                    fr_crc   = crc16_next(fr_crc, b);
                    fr_phase = crcfr_pkg::PH_LEN_LO;
                end
                crcfr_pkg::PH_LEN_LO: begin
                    fr_len[7:0] = b;
                    fr_crc      = crc16_next(fr_crc, b);
                    fr_count    = 16'h0000;
                    if (fr_len > max_len_cfg) begin
                        post_result(crcfr_pkg::KIND_STATUS, 8'h00,
                                    crcfr_pkg::ST_OVERFLOW, 1'b1);
                        return_to_hunt();
                    end else begin
                        fr_phase = (fr_len == 16'h0000) ? crcfr_pkg::PH_CRC_HI
                                                        : crcfr_pkg::PH_PAYLOAD;
                    end
                end
                crcfr_pkg::PH_PAYLOAD: begin
                    fr_crc   = crc16_next(fr_crc, b);
                    fr_count = fr_count + 16'd1;
                    if (fr_count >= fr_len)
                        fr_phase = crcfr_pkg::PH_CRC_HI;
                    post_result(crcfr_pkg::KIND_PAYLOAD, b, crcfr_pkg::ST_OK, 1'b1);
                end
                crcfr_pkg::PH_CRC_HI: begin
                    fr_crc_hi = b;
                    fr_phase  = crcfr_pkg::PH_CRC_LO;
                end
                crcfr_pkg::PH_CRC_LO: begin
                    if (fr_crc_hi != fr_crc[15:8] || b != fr_crc[7:0])
                        st = crcfr_pkg::ST_BAD_CRC;
                    else if (fr_type > 8'd63 || !type_mask_cfg[fr_type[5:0]])
                        st = crcfr_pkg::ST_BAD_TYPE;
                    else
                        st = crcfr_pkg::ST_OK;
                    post_result(crcfr_pkg::KIND_STATUS, 8'h00, st, 1'b1);
                    return_to_hunt();
                end
                default: return_to_hunt();
            endcase
        end
    endtask

    task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= REPORT_LINES)
            $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    always @(posedge i_clk) begin : driver
        t_rx_word w;
        if (!i_rst_n) begin
            rx_if.valid <= 1'b0;
        end else begin
            if (rx_if.valid && rx_if.ready)
                deframe_step(rx_if.rx_byte, rx_if.restart);
            if (!rx_if.valid || rx_if.ready) begin
                if (pending_q.size() != 0 && !send_hold &&
                    $urandom_range(99) >= send_idle_pct) begin
                    w = pending_q.pop_front();
                    rx_if.valid   <= 1'b1;
                    rx_if.rx_byte <= w.rx_byte;
                    rx_if.restart <= w.restart;
                end else begin
                    rx_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        crcfr_pkg::t_result want;
        res_if.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_q.size() == 0) begin
                flag_mismatch("result with nothing expected",
                              64'({res_if.kind, res_if.payload_byte, res_if.status}),
                              64'h0);
            end else begin
                want = expected_q.pop_front();
                if (res_if.kind !== want.kind)
                    flag_mismatch("kind", 64'(res_if.kind), 64'(want.kind));
                if (res_if.payload_byte !== want.payload_byte)
                    flag_mismatch("payload_byte", 64'(res_if.payload_byte),
                                  64'(want.payload_byte));
                if (res_if.status !== want.status)
                    flag_mismatch("status", 64'(res_if.status), 64'(want.status));
                if (res_if.frame_type !== want.frame_type)
                    flag_mismatch("frame_type", 64'(res_if.frame_type),
                                  64'(want.frame_type));
                if (res_if.answer_start !== want.answer_start)
                    flag_mismatch("answer_start", 64'(res_if.answer_start),
                                  64'(want.answer_start));
                if (res_if.frame_length !== want.frame_length)
                    flag_mismatch("frame_length", 64'(res_if.frame_length),
                                  64'(want.frame_length));
            end
        end
    end

    task automatic push_word(logic [7:0] b, logic abort);
        pending_q.push_back(t_rx_word'{rx_byte: b, restart: abort});
        pushed_total++;
    endtask

    task automatic queue_frame(logic [7:0] start_b, logic [7:0] ftype, logic [15:0] flen,
                               bit bad_crc, int cut_at);
        logic [7:0]  words[$];
        logic [15:0] crc;
        words = '{start_b, ftype, flen[15:8], flen[7:0]};
        if (flen <= max_len_cfg) begin
            for (int i = 0; i < flen; i++)
                words.push_back(8'($urandom_range(255)));
            crc = crcfr_pkg::CRC_INIT;
            foreach (words[i])
                crc = crc16_next(crc, words[i]);
            if (bad_crc)
                crc ^= 16'h0001 << $urandom_range(15);
            words.push_back(crc[15:8]);
            words.push_back(crc[7:0]);
        end
        for (int i = 0; i < words.size() && (cut_at < 0 || i < cut_at); i++)
            push_word(words[i], 1'b0);
    endtask

    task automatic queue_random_traffic(int n_words);
        int          first;
        int          pick;
        int          lim;
        logic [7:0]  start_b;
        logic [7:0]  ftype;
        logic [15:0] flen;
        first = pushed_total;
        while (pushed_total - first < n_words) begin
            pick    = $urandom_range(99);
            start_b = $urandom_range(1) ? crcfr_pkg::START_ANSWER : crcfr_pkg::START_PLAIN;
            ftype   = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                               : 8'($urandom_range(63));
            lim     = (max_len_cfg < 16'd12) ? int'(max_len_cfg) : 12;
            flen    = 16'($urandom_range(lim));
            if (max_len_cfg != 16'hFFFF && $urandom_range(7) == 0)
                flen = 16'($urandom_range(65535, max_len_cfg + 1));
            else if (max_len_cfg <= 16'd40 && $urandom_range(9) == 0)
                flen = max_len_cfg;
            if (pick < 72) begin
                queue_frame(start_b, ftype, flen, $urandom_range(4) == 0, -1);
            end else if (pick < 82) begin
                queue_frame(start_b, ftype, flen, 1'b0, $urandom_range(10, 1));
                if ($urandom_range(1))
                    push_word(8'($urandom_range(255)), 1'b1);
            end else if (pick < 92) begin
                repeat ($urandom_range(4, 1))
                    push_word(8'($urandom_range(255)), 1'b0);
            end else begin
                push_word(8'($urandom_range(255)), 1'b1);
            end
        end
    endtask

    task automatic write_reg(logic [crcfr_pkg::CFG_INDEX_W-1:0] idx, logic [63:0] value);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == crcfr_pkg::REG_MAX_PAYLOAD)
            max_len_cfg = value[15:0];
        else if (idx == crcfr_pkg::REG_TYPE_MASK)
            type_mask_cfg = value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_q.size() != 0 || rx_if.valid || expected_q.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    initial begin : sequencer
        logic [15:0] max_plan[RANDOM_PHASES];
        logic [63:0] mask_plan[RANDOM_PHASES];
        i_rst_n       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = 8'h00;
        rx_if.restart = 1'b0;
        res_if.ready  = 1'b0;
        max_plan  = '{crcfr_pkg::MAX_PAYLOAD_RESET, 16'd0, 16'hFFFF, 16'd12, 16'd20,
                      16'd40};
        mask_plan = '{crcfr_pkg::TYPE_MASK_RESET, '1, 64'h0, {$urandom, $urandom},
                      64'h8000_0000_0000_0001, {$urandom, $urandom}};
        send_idle_pct = 13;
        recv_idle_pct = 45;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        push_word(8'h00, 1'b0);
        push_word(8'hFF, 1'b1);
        push_word(8'hFF, 1'b0);
        queue_frame(crcfr_pkg::START_ANSWER, 8'h00, 16'd1, 1'b0, -1);
        queue_frame(crcfr_pkg::START_PLAIN, 8'hFF, 16'd0, 1'b1, -1);
        queue_frame(crcfr_pkg::START_ANSWER, 8'h3F, 16'd0, 1'b0, -1);
        queue_frame(crcfr_pkg::START_PLAIN, 8'hFF, 16'hFFFF, 1'b0, -1);
        wait_drained();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_reg(crcfr_pkg::REG_MAX_PAYLOAD, {48'h0, max_plan[p]});
            write_reg(crcfr_pkg::REG_TYPE_MASK, mask_plan[p]);
            if (p == 3) begin
                write_reg(REG_SPARE_2, {$urandom, $urandom});
                write_reg(REG_SPARE_3, {$urandom, $urandom});
            end
            if (p < 2) begin
                send_idle_pct = 13;
                recv_idle_pct = 45;
            end else if (p < 4) begin
                send_idle_pct = 45;
                recv_idle_pct = 13;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            @(negedge i_clk);
            queue_random_traffic(WORDS_PER_PHASE);
            if (p == 0) begin
                fork
                    begin
                        recv_hold = 1'b1;
                        repeat (160) @(negedge i_clk);
                        recv_hold = 1'b0;
                    end
                join_none
            end
            if (p == 2) begin
                while (pending_q.size() > WORDS_PER_PHASE / 2)
                    @(negedge i_clk);
                send_hold = 1'b1;
                while (expected_q.size() != 0 || rx_if.valid)
                    @(negedge i_clk);
                send_hold = 1'b0;
            end
            wait_drained();
        end

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin : watchdog
        #3ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
